@@ hw/rtl/oult_pkg.sv @@
// oult_pkg: shared types, codes and defaults for the ordered unique list table.
// No dependencies; used by every module under hw/rtl.
`default_nettype none
package oult_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OFF_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 5;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INS_AT  = 3'd0,
    REQ_INS_BOT = 3'd1,
    REQ_REM_AT  = 3'd2,
    REQ_REM_KEY = 3'd3,
    REQ_MOVE    = 3'd4,
    REQ_FIND    = 3'd5
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_OFFSET   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOCHANGE = 3'd4
  } status_e;

  // what a cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_PREV = 2'd2,
    CELL_NEXT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
  } cell_ctl_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [KEY_W-1:0]  key;
    logic [OFF_W-1:0]  offset;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    entry_count;
  } rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/ordered_unique_list_table.sv @@
// ordered_unique_list_table: top level; request/response handshakes, sequencer,
// entry count and the row of oult_cell slots. Depends on oult_pkg, oult_cell, oult_ctrl.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+-------------------------------
//   req     | in        | req_valid_i / req_ready_o | oult_pkg::req_t (type,key,off)
//   rsp     | out       | rsp_valid_o / rsp_ready_i | oult_pkg::rsp_t (status,pos,cnt)
//
// Each request has a compare cycle where every cell matches its key against the
// request, then an execute cycle where the decode shifts the cells on one side
// of the target slot by at most one slot and the response is registered.
// A new request is taken in the execute cycle of the one before; none during a compare.
// A response that is not taken holds the block in execute; no new word enters.
// Reset clears the count, sequencer and response valid; keys need no clearing.
`default_nettype none
module ordered_unique_list_table #(
  parameter int unsigned CAPACITY  = oult_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = oult_pkg::KEY_WIDTH_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  oult_pkg::req_t  req_i,
  input  wire             req_valid_i,
  output logic            req_ready_o,
  output oult_pkg::rsp_t  rsp_o,
  output logic            rsp_valid_o,
  input  wire             rsp_ready_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // sequencer
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]          state_q, state_d;
  oult_pkg::req_t      req_q;
  logic [CW-1:0]       count_q, count_d;
  oult_pkg::rsp_t      rsp_q, rsp_d;
  oult_pkg::rsp_t      rsp_d_raw;
  logic                rsp_valid_q, rsp_valid_d;
  logic                accept, exec_fire;

  logic [KEY_WIDTH+oult_pkg::KEY_W-1:0] key_ext;
  logic [KEY_WIDTH-1:0]                 req_key;

  logic [KEY_WIDTH-1:0]  cell_key [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   cell_valid;
  oult_pkg::cell_ctl_t   cell_ctl [CAPACITY];
  logic [CW-1:0]         count_next;

  // execute only when the response slot is free or being drained
  assign exec_fire   = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = (state_q == S_IDLE) || exec_fire;
  assign accept      = req_valid_i && req_ready_o;

  // key field is fixed at 32 bits; keep the low KEY_WIDTH bits
  assign key_ext = {{KEY_WIDTH{1'b0}}, req_q.key};
  assign req_key = key_ext[KEY_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < int'(CAPACITY); i++) begin
      cell_valid[i] = CW'(i) < count_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_LOOK;
      S_LOOK:  state_d = S_EXEC;
      S_EXEC:  if (exec_fire) state_d = accept ? S_LOOK : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = exec_fire ? count_next : count_q;
    rsp_valid_d = exec_fire ? 1'b1 : (rsp_valid_q && !rsp_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  oult_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .req_i        (req_q),
    .match_i      (match),
    .count_i      (count_q),
    .look_i       (state_q == S_LOOK),
    .exec_i       (exec_fire),
    .ctl_o        (cell_ctl),
    .rsp_o        (rsp_d_raw),
    .count_next_o (count_next)
  );

  assign rsp_d = exec_fire ? rsp_d_raw : rsp_q;

  // row of cells; slot 0 is the top of the list
  for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
    logic [KEY_WIDTH-1:0] prev_key, next_key;
    if (g == 0) begin : g_first
      assign prev_key = cell_key[g];
    end else begin : g_mid_p
      assign prev_key = cell_key[g-1];
    end
    if (g == int'(CAPACITY) - 1) begin : g_last
      assign next_key = cell_key[g];
    end else begin : g_mid_n
      assign next_key = cell_key[g+1];
    end
    oult_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl[g]),
      .valid_i    (cell_valid[g]),
      .req_key_i  (req_key),
      .prev_key_i (prev_key),
      .next_key_i (next_key),
      .key_o      (cell_key[g]),
      .match_o    (match[g])
    );
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // ---------------------------------------------------------------- checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(match))
    else $error("key matched in more than one cell");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_LOOK))
    else $error("accepted word did not enter compare cycle");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_fire |=> $stable(count_q))
    else $error("count changed outside execute");

endmodule
`default_nettype wire

@@ hw/rtl/oult_cell.sv @@
// oult_cell: one list slot; holds a key, compares it, shifts with neighbors.
// Depends on oult_pkg.
`default_nettype none
module oult_cell #(
  parameter int unsigned KEY_WIDTH = oult_pkg::KEY_WIDTH_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  oult_pkg::cell_ctl_t    ctl_i,
  input  wire                    valid_i,
  input  wire  [KEY_WIDTH-1:0]   req_key_i,
  input  wire  [KEY_WIDTH-1:0]   prev_key_i,
  input  wire  [KEY_WIDTH-1:0]   next_key_i,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic                   match_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 match_q;

  always_comb begin
    case (ctl_i.op)
      oult_pkg::CELL_LOAD: key_d = req_key_i;
      oult_pkg::CELL_PREV: key_d = prev_key_i;
      oult_pkg::CELL_NEXT: key_d = next_key_i;
      default:             key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      match_q <= valid_i && (key_q == req_key_i);
    end
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

@@ hw/rtl/oult_ctrl.sv @@
// oult_ctrl: decodes a request against the match row and count; drives the
// per-cell shift controls and builds the response. Depends on oult_pkg.
`default_nettype none
module oult_ctrl #(
  parameter int unsigned CAPACITY = oult_pkg::CAPACITY_DEF,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  oult_pkg::req_t       req_i,
  input  wire  [CAPACITY-1:0]  match_i,
  input  wire  [CW-1:0]        count_i,
  input  wire                  look_i,
  input  wire                  exec_i,
  output oult_pkg::cell_ctl_t  ctl_o [CAPACITY],
  output oult_pkg::rsp_t       rsp_o,
  output logic [CW-1:0]        count_next_o
);

  localparam int unsigned WW = (CW > oult_pkg::OFF_W) ? CW : oult_pkg::OFF_W;

  logic [CW-1:0] hit_pos;
  logic          found;
  logic [WW-1:0] off_w, cnt_w, pos_w;
  logic          off_gt, off_lt, full;
  logic          ins, rem, mov;
  logic [CW-1:0] tgt;

  // one-hot match row to index
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      if (match_i[i]) hit_pos = hit_pos | CW'(i);
    end
  end

  assign found  = |match_i;
  assign off_w  = WW'(req_i.offset);
  assign cnt_w  = WW'(count_i);
  assign off_gt = off_w > cnt_w;
  assign off_lt = off_w < cnt_w;
  assign full   = count_i == CW'(CAPACITY);

  always_comb begin
    logic [oult_pkg::STATUS_W-1:0] st;
    logic [CW-1:0]                 pos;
    logic [WW-1:0]                 cn_w;
    st           = oult_pkg::ST_NOCHANGE;
    pos          = '0;
    ins          = 1'b0;
    rem          = 1'b0;
    mov          = 1'b0;
    tgt          = '0;
    count_next_o = count_i;
    unique case (req_i.req_type)
      oult_pkg::REQ_INS_AT, oult_pkg::REQ_INS_BOT: begin
        tgt = (req_i.req_type == oult_pkg::REQ_INS_AT) ? off_w[CW-1:0] : count_i;
        if ((req_i.req_type == oult_pkg::REQ_INS_AT) && off_gt) begin
          st = oult_pkg::ST_OFFSET;
        end else if (found) begin
          st = oult_pkg::ST_DUP;
        end else if (full) begin
          st = oult_pkg::ST_FULL;
        end else begin
          st           = oult_pkg::ST_DONE;
          ins          = 1'b1;
          count_next_o = count_i + CW'(1);
        end
      end
      oult_pkg::REQ_REM_AT: begin
        tgt = off_w[CW-1:0];
        if (off_lt) begin
          st           = oult_pkg::ST_DONE;
          rem          = 1'b1;
          count_next_o = count_i - CW'(1);
        end
      end
      oult_pkg::REQ_REM_KEY: begin
        tgt = hit_pos;
        if (found) begin
          st           = oult_pkg::ST_DONE;
          rem          = 1'b1;
          count_next_o = count_i - CW'(1);
        end
      end
      oult_pkg::REQ_MOVE: begin
        tgt = hit_pos;
        if (found) begin
          st  = oult_pkg::ST_DONE;
          mov = 1'b1;
        end
      end
      oult_pkg::REQ_FIND: begin
        st  = oult_pkg::ST_DONE;
        pos = found ? hit_pos : count_i;
      end
      default: begin
        st = oult_pkg::ST_NOCHANGE;
      end
    endcase
    pos_w                 = WW'(pos);
    cn_w                  = WW'(count_next_o);
    rsp_o.status          = st;
    rsp_o.position        = pos_w[oult_pkg::POS_W-1:0];
    rsp_o.entry_count     = cn_w[oult_pkg::POS_W-1:0];
  end

  // per-cell shift control relative to the target slot
  always_comb begin
    for (int i = 0; i < int'(CAPACITY); i++) begin
      ctl_o[i].cmp_en = look_i;
      ctl_o[i].op     = oult_pkg::CELL_HOLD;
      if (exec_i) begin
        if (ins) begin
          if (CW'(i) == tgt)     ctl_o[i].op = oult_pkg::CELL_LOAD;
          else if (CW'(i) > tgt) ctl_o[i].op = oult_pkg::CELL_PREV;
        end else if (rem) begin
          if (CW'(i) >= tgt)     ctl_o[i].op = oult_pkg::CELL_NEXT;
        end else if (mov) begin
          if (i == 0)             ctl_o[i].op = oult_pkg::CELL_LOAD;
          else if (CW'(i) <= tgt) ctl_o[i].op = oult_pkg::CELL_PREV;
        end
      end
    end
  end

endmodule
`default_nettype wire
